@@ hw/rtl/sm3_pkg.sv @@
// sm3_pkg: shared constants, types and round functions of the sm3 hash engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

    localparam logic [31:0] TJ_LOW   = 32'h79cc4519;
    localparam logic [31:0] TJ_HIGH  = 32'h7a879d8a;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef logic [31:0] word_t;

    // one classified item as handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } item_t;

    function automatic word_t sm3_iv(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0: v = 32'h7380166f;
            3'd1: v = 32'h4914b2b9;
            3'd2: v = 32'h172442d7;
            3'd3: v = 32'hda8a0600;
            3'd4: v = 32'ha96f30bc;
            3'd5: v = 32'h163138aa;
            3'd6: v = 32'he38dee4d;
            default: v = 32'hb0fb0e4e;
        endcase
        return v;
    endfunction

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sm3_front.sv @@
// sm3_front: input queue between the push side and the compression back end
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire sm3_pkg::item_t in_item,
    output logic               q_valid,
    input  wire logic          q_take,
    output sm3_pkg::item_t     q_item
);
    import sm3_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    item_t         slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    // items with neither a byte nor an end carry no work and are dropped here
    assign full    = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign do_push = push && !full && (in_item.byte_valid || in_item.end_of_message);
    assign q_valid = (count_reg != '0);
    assign do_pop  = q_valid && q_take;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

    property p_pop_nonempty;
        @(posedge clk) disable iff (!rst_n) do_pop |-> count_reg != '0;
    endproperty
    a_pop_nonempty: assert property (p_pop_nonempty)
        else $error("sm3_front: pop of empty queue");
    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= (AW+1)'(QUEUE_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("sm3_front: overflow");
    property p_ptr_gap;
        @(posedge clk) disable iff (!rst_n)
            (count_reg != (AW+1)'(QUEUE_DEPTH)) && (count_reg != '0)
            |-> wr_ptr_reg != rd_ptr_reg;
    endproperty
    a_ptr_gap: assert property (p_ptr_gap) else $error("sm3_front: pointer mismatch");
endmodule
`default_nettype wire

@@ hw/rtl/sm3_back.sv @@
// sm3_back: block buffer, padding, message expansion and 64-round compression
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_take,
    input  wire sm3_pkg::item_t q_item,
    output logic                empty,
    input  wire logic           pop,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    import sm3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [63:0] len_reg;
    word_t       cv_reg [8];
    word_t       r_reg [8];
    word_t       blk_reg [16];      // block buffer, packed big-endian words
    word_t       w_reg [16];        // sliding window of expanded words
    logic [5:0]  rnd_reg;
    logic [1:0]  pad_reg;           // 0 none, 1 length block, 2 pad mark then length
    logic        fin_reg;           // this block ends the message
    logic [2:0]  oidx_reg;

    logic [5:0]  pos;
    word_t       wnew, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

    assign pos = len_reg[8:3];

    assign q_take = (state_reg == ST_IDLE) && q_valid;
    assign empty  = (state_reg != ST_OUT);
    assign digest_word = cv_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    always_comb
    begin
        wnew = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
             ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
        tj  = (rnd_reg < 6'd16) ? TJ_LOW : TJ_HIGH;
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + rotl(tj, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid && (q_item.end_of_message ||
                         (q_item.byte_valid && pos == 6'd63)))
                         state_next = ST_LOAD;
            ST_LOAD: state_next = ST_RND;
            ST_RND:  if (rnd_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD: state_next = (pad_reg != 2'd0) ? ST_LOAD
                                : (fin_reg ? ST_OUT : ST_IDLE);
            ST_OUT:  if (pop && oidx_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            rnd_reg   <= '0;
            pad_reg   <= '0;
            fin_reg   <= 1'b0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= sm3_iv(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        logic [63:0] nl;
                        logic [5:0]  p;
                        nl = len_reg + (q_item.byte_valid ? 64'd8 : 64'd0);
                        p  = nl[8:3];
                        if (q_item.byte_valid)
                            len_reg <= nl;
                        fin_reg <= 1'b0;
                        pad_reg <= 2'd0;
                        if (q_item.end_of_message)
                        begin
                            if (q_item.byte_valid && pos == 6'd63)
                                pad_reg <= 2'd2;        // full block, then pad mark and length
                            else if (p > 6'd55)
                                pad_reg <= 2'd1;
                            else
                                fin_reg <= 1'b1;
                        end
                    end
                end
                ST_LOAD: rnd_reg <= '0;
                ST_RND:  rnd_reg <= rnd_reg + 1'b1;
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        cv_reg[i] <= cv_reg[i] ^ r_reg[i];
                    if (pad_reg != 2'd0)
                    begin
                        pad_reg <= 2'd0;
                        fin_reg <= 1'b1;
                    end
                    oidx_reg <= '0;
                end
                ST_OUT:
                begin
                    if (pop)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        if (oidx_reg == 3'd7)
                        begin
                            len_reg <= '0;
                            for (int i = 0; i < 8; i++)
                                cv_reg[i] <= sm3_iv(3'(i));
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: block buffer, expansion window and round registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    logic [5:0]  p2;
                    logic [63:0] nl2;
                    p2  = pos + (q_item.byte_valid ? 6'd1 : 6'd0);
                    nl2 = len_reg + (q_item.byte_valid ? 64'd8 : 64'd0);
                    if (q_item.byte_valid)
                        blk_reg[pos[5:2]][8*(3-pos[1:0]) +: 8] <= q_item.data_byte;
                    if (q_item.end_of_message && !(q_item.byte_valid && pos == 6'd63))
                    begin
                        // pad mark, zero tail, length when it fits
                        for (int k = 0; k < 64; k++)
                            if (6'(k) == p2)
                                blk_reg[k/4][8*(3-k%4) +: 8] <= PAD_MARK;
                            else if (6'(k) > p2)
                                blk_reg[k/4][8*(3-k%4) +: 8] <= 8'h00;
                        if (p2 <= 6'd55)
                        begin
                            blk_reg[14] <= nl2[63:32];
                            blk_reg[15] <= nl2[31:0];
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                for (int i = 0; i < 16; i++)
                    w_reg[i] <= blk_reg[i];
                for (int i = 0; i < 8; i++)
                    r_reg[i] <= cv_reg[i];
            end
            ST_RND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wnew;
                r_reg[3] <= r_reg[2];
                r_reg[2] <= rotl(r_reg[1], 5'd9);
                r_reg[1] <= r_reg[0];
                r_reg[0] <= tt1;
                r_reg[7] <= r_reg[6];
                r_reg[6] <= rotl(r_reg[5], 5'd19);
                r_reg[5] <= r_reg[4];
                r_reg[4] <= perm0(tt2);
            end
            ST_FOLD:
            begin
                if (pad_reg != 2'd0)
                begin
                    for (int i = 0; i < 14; i++)
                        blk_reg[i] <= '0;
                    if (pad_reg == 2'd2)
                        blk_reg[0] <= {PAD_MARK, 24'h0};
                    blk_reg[14] <= len_reg[63:32];
                    blk_reg[15] <= len_reg[31:0];
                end
            end
            default: ;
        endcase
    end

    property p_out_stable;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_OUT) && !pop |=> $stable(oidx_reg);
    endproperty
    a_out_stable: assert property (p_out_stable) else $error("sm3_back: index moved");
    property p_no_take_busy;
        @(posedge clk) disable iff (!rst_n)
            (state_reg != ST_IDLE) |-> !q_take;
    endproperty
    a_no_take_busy: assert property (p_no_take_busy) else $error("sm3_back: take while busy");
    property p_out_after_fold;
        @(posedge clk) disable iff (!rst_n)
            $rose(state_reg == ST_OUT) |-> $past(state_reg) == ST_FOLD;
    endproperty
    a_out_after_fold: assert property (p_out_after_fold) else $error("sm3_back: bad entry");
endmodule
`default_nettype wire

@@ hw/rtl/sm3_hash_engine_top.sv @@
// sm3_hash_engine_top: sm3 hash of a byte stream, front queue plus compression back end
// depends on sm3_pkg, sm3_front, sm3_back
//
// channel  direction  handshake       payload
// input    in         push / full     data_byte, byte_valid, end_of_message
// result   out        empty / pop     digest_word, word_index, last_word
//
// a byte that does not close a block is taken into the block buffer while the back end stays idle
// a byte that closes a block then runs load, 64 rounds and fold
// end of message adds one or two compressions, then eight result transfers
// a four-entry queue lets the input side keep pushing while the back end works
// rst_n is asynchronous; after reset the chaining value holds the iv
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sm3_pkg::*;

    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_take;

    assign in_item.data_byte      = data_byte;
    assign in_item.byte_valid     = byte_valid;
    assign in_item.end_of_message = end_of_message;

    // front: queue of classified items
    sm3_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    // back: buffer, padding, expansion, rounds and digest transfer
    sm3_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_item      (q_item),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking testbench of sm3_hash_engine_top, digest predictor plus scoreboard
// depends on sm3_pkg (word type) and sm3_hash_engine_top
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import sm3_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } digest_xfer_t;

    // scoreboard: running hash of the message seen so far, queue of pending digest words
    class digest_board;
        word_t        chain[8];
        logic [7:0]   blk[64];
        logic [63:0]  bit_len;
        digest_xfer_t pending[$];
        int           errors;

        function void init();
            for (int i = 0; i < 8; i++)
                chain[i] = iv_word(i);
            for (int i = 0; i < 64; i++)
                blk[i] = 8'h00;
            bit_len = 64'd0;
            errors = 0;
        endfunction

        static function word_t iv_word(int i);
            word_t v[8];
            v = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                  32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
            return v[i];
        endfunction

        static function word_t rol(word_t x, int n);
            n = n % 32;
            if (n == 0)
                return x;
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            word_t w[68];
            word_t r[8];
            word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2, t;
            for (int j = 0; j < 16; j++)
                w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
            for (int j = 16; j < 68; j++)
            begin
                t = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
                w[j] = t ^ rol(t, 15) ^ rol(t, 23) ^ rol(w[j-13], 7) ^ w[j-6];
            end
            r = chain;
            for (int j = 0; j < 64; j++)
            begin
                tj  = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
                a12 = rol(r[0], 12);
                ss1 = rol(a12 + r[4] + rol(tj, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16)
                begin
                    ff = r[0] ^ r[1] ^ r[2];
                    gg = r[4] ^ r[5] ^ r[6];
                end
                else
                begin
                    ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                    gg = (r[4] & r[5]) | (~r[4] & r[6]);
                end
                tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
                tt2 = gg + r[7] + ss1 + w[j];
                r[3] = r[2];
                r[2] = rol(r[1], 9);
                r[1] = r[0];
                r[0] = tt1;
                r[7] = r[6];
                r[6] = rol(r[5], 19);
                r[5] = r[4];
                r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
            end
            for (int j = 0; j < 8; j++)
                chain[j] ^= r[j];
        endfunction

        // note one accepted input transfer
        function void note_input(logic [7:0] b, logic bv, logic eom);
            int p;
            digest_xfer_t x;
            if (bv)
            begin
                p = bit_len[8:3];
                blk[p] = b;
                bit_len += 64'd8;
                if (p == 63)
                    compress();
            end
            if (!eom)
                return;
            p = bit_len[8:3];
            blk[p] = 8'h80;
            for (int i = p + 1; i < 64; i++)
                blk[i] = 8'h00;
            if (p > 55)
            begin
                compress();
                for (int i = 0; i < 64; i++)
                    blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk[56+i] = bit_len[8*(7-i) +: 8];
            compress();
            for (int k = 0; k < 8; k++)
            begin
                x.digest_word = chain[k];
                x.word_index  = 3'(k);
                x.last_word   = (k == 7);
                pending.push_back(x);
            end
            for (int i = 0; i < 8; i++)
                chain[i] = iv_word(i);
            bit_len = 64'd0;
        endfunction

        // compare one accepted result transfer against the oldest expectation
        function void check_result(word_t dw, logic [2:0] wi, logic lw);
            digest_xfer_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: digest_word %h", dw);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (dw !== x.digest_word)
            begin
                $error("digest_word: expected %h, got %h", x.digest_word, dw);
                errors++;
            end
            if (wi !== x.word_index)
            begin
                $error("word_index: expected %0d, got %0d", x.word_index, wi);
                errors++;
            end
            if (lw !== x.last_word)
            begin
                $error("last_word: expected %0d, got %0d", x.last_word, lw);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty, last_word;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    digest_board board;
    int  idle_cycles = 0;
    bit  pop_quiet = 1'b0;   // stretches where the receiver never stalls

    sm3_hash_engine_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .byte_valid(byte_valid),
        .end_of_message(end_of_message), .empty(empty), .pop(pop),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitor: both handshakes sampled at the rising edge, before the driver updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_input(data_byte, byte_valid, end_of_message);
            if (pop && !empty)
                board.check_result(digest_word, word_index, last_word);
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: ends the run with errors when nothing moves for too long
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver: stalls on its own pattern, with calm stretches
    always @(posedge clk)
    begin
        if (pop_quiet)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    always
    begin
        repeat ($urandom_range(50, 400)) @(posedge clk);
        pop_quiet = ~pop_quiet;
    end

    // one input transfer; holds push high until it is taken
    task automatic send(logic [7:0] b, logic bv, logic eom);
        push <= 1'b1;
        data_byte <= b;
        byte_valid <= bv;
        end_of_message <= eom;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic pause();
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // one message of n or n+1 bytes with random content, noise items mixed in when noisy
    task automatic send_message(int n, bit noisy);
        int burst;
        burst = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            if (--burst == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    pause();
                burst = $urandom_range(1, 16);
            end
        end
        // close with the last byte or with a byte-less end marker
        if ($urandom_range(0, 1))
            send(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        else
            send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int sent;
        board = new();
        board.init();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, "abc", byte extremes, an ignored byte
        send(8'hff, 1'b0, 1'b1);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        send(8'h63, 1'b1, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'hff, 1'b0, 1'b0);
        send(8'hff, 1'b1, 1'b1);
        send(8'h55, 1'b1, 1'b0);
        send(8'haa, 1'b1, 1'b1);
        // sender holds off until every digest word is back
        wait_drained();

        // padding borders: 55, 56 and 63 bytes, plus an optional closing byte, need one or two blocks
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b0);
        wait_drained();

        // random messages, mostly short, a few spanning several blocks
        sent = 0;
        while (sent < 60)
        begin
            int n;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140)
                                            : $urandom_range(0, 20);
            send_message(n, 1'b1);
            sent += n + 1;
        end
        push <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
